@@ hw/rtl/afsc_pkg.sv @@
// shared types, constants and crc helper for the angle frame safety check
package afsc_pkg;

    localparam logic [7:0]  CRC_POLY       = 8'h1D;
    localparam logic [7:0]  CRC_INIT       = 8'hFF;
    localparam logic [15:0] CMD_WORD_RESET = 16'h8021;

    localparam int unsigned BIT_SYSTEM     = 14;
    localparam int unsigned BIT_INTERFACE  = 13;
    localparam int unsigned BIT_INV_ANGLE  = 12;
    localparam int unsigned ANGLE_W        = 15;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SYSTEM    = 3'd1,
        ERR_INTERFACE = 3'd2,
        ERR_INV_ANGLE = 3'd3,
        ERR_CRC       = 3'd4
    } err_code_t;

    // result of the frame check, handed to the output stage
    typedef struct packed {
        logic [ANGLE_W-1:0] new_angle;
        logic               ok;
        err_code_t          err;
        logic [15:0]        safety;
    } check_t;

    // eight shifts of the crc register after the next byte is xor-ed in
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/afsc_check.sv @@
// status bit priority check and crc-8 compare for one registered frame
module afsc_check (
    input  logic [15:0]     cmd_word,
    input  logic [15:0]     angle_word,
    input  logic [15:0]     safety_word,
    output afsc_pkg::check_t result
);

    logic [7:0] crc_c0;
    logic [7:0] crc_c1;
    logic [7:0] crc_a0;
    logic [7:0] crc_a1;
    logic [7:0] crc_final;

    always_comb begin
        crc_c0    = afsc_pkg::crc_byte(afsc_pkg::CRC_INIT, cmd_word[15:8]);
        crc_c1    = afsc_pkg::crc_byte(crc_c0, cmd_word[7:0]);
        crc_a0    = afsc_pkg::crc_byte(crc_c1, angle_word[15:8]);
        crc_a1    = afsc_pkg::crc_byte(crc_a0, angle_word[7:0]);
        crc_final = ~crc_a1;
    end

    always_comb begin
        result.new_angle = angle_word[afsc_pkg::ANGLE_W-1:0];
        result.safety    = safety_word;
        // status bits are active low, system wins over interface over angle
        priority if (!safety_word[afsc_pkg::BIT_SYSTEM]) begin
            result.err = afsc_pkg::ERR_SYSTEM;
        end else if (!safety_word[afsc_pkg::BIT_INTERFACE]) begin
            result.err = afsc_pkg::ERR_INTERFACE;
        end else if (!safety_word[afsc_pkg::BIT_INV_ANGLE]) begin
            result.err = afsc_pkg::ERR_INV_ANGLE;
        end else if (crc_final != safety_word[7:0]) begin
            result.err = afsc_pkg::ERR_CRC;
        end else begin
            result.err = afsc_pkg::ERR_NONE;
        end
        result.ok = (result.err == afsc_pkg::ERR_NONE);
    end

endmodule

@@ hw/rtl/afsc_out_stage.sv @@
// result register and held angle
module afsc_out_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  afsc_pkg::check_t              check,
    output logic                          stage_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [afsc_pkg::ANGLE_W-1:0]  m_angle,
    output logic                          m_valid_res,
    output logic [2:0]                    m_error_code,
    output logic                          m_reset_request,
    output logic [15:0]                   m_last_safety
);

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [afsc_pkg::ANGLE_W-1:0] held_angle_reg;
    logic [afsc_pkg::ANGLE_W-1:0] held_angle_next;
    logic [afsc_pkg::ANGLE_W-1:0] angle_reg;
    logic                         ok_reg;
    afsc_pkg::err_code_t          err_reg;
    logic [15:0]                  safety_reg;

    assign stage_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        held_angle_next = held_angle_reg;
        if (load) begin
            out_valid_next = 1'b1;
            if (check.ok) begin
                held_angle_next = check.new_angle;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            held_angle_reg <= '0;
        end else begin
            out_valid_reg  <= out_valid_next;
            held_angle_reg <= held_angle_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            angle_reg  <= held_angle_next;
            ok_reg     <= check.ok;
            err_reg    <= check.err;
            safety_reg <= check.safety;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_angle         = angle_reg;
    assign m_valid_res     = ok_reg;
    assign m_error_code    = err_reg;
    assign m_reset_request = !ok_reg;
    assign m_last_safety   = safety_reg;

    // held angle only moves on a passing frame
    a_held_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !(load && check.ok) |=> $stable(held_angle_reg))
        else $error("held angle changed without a passing frame");

    // a presented result always carries the current held angle
    a_angle_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (angle_reg == held_angle_reg))
        else $error("output angle differs from held angle");

    // pass flag and error code agree
    a_ok_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (ok_reg == (err_reg == afsc_pkg::ERR_NONE)))
        else $error("pass flag and error code disagree");

    // no new result is loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !load)
        else $error("result overwritten while stalled");

endmodule

@@ hw/rtl/angle_frame_safety_check.sv @@
// angle frame safety check: status bit and crc-8 check of sensor responses
//
// one transaction on the s_ channel carries a raw angle word and a safety
// word; one transaction on the m_ channel returns the checked result.
// status bits 14..12 of the safety word are active low and checked in order
// system, interface, invalid angle; if all pass, a crc-8 over the command
// word and the angle word is compared with the safety word's low byte.
// a pass outputs and stores the 15-bit angle; any error outputs the stored
// angle, the error code and a reset request.
// m_valid rises once an accepted transaction has passed the input register,
// then the result register; throughput is one transaction per cycle while
// m_ready is high, set by the single-pass crc and priority logic between them.
// cfg_wr_en/cfg_wr_data write the command word; write only while idle.
// reset (aresetn low, synchronous) empties both stages, clears the held
// angle and loads the command word with 0x8021.
// when the receiver stalls, the result register holds its transaction and
// one more is kept in the input register before s_ready drops.
module angle_frame_safety_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [15:0]                   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [15:0]                   s_angle_word,
    input  logic [15:0]                   s_safety_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [afsc_pkg::ANGLE_W-1:0]  m_angle,
    output logic                          m_valid_res,
    output logic [2:0]                    m_error_code,
    output logic                          m_reset_request,
    output logic [15:0]                   m_last_safety
);

    logic             cmd_word_reg;
    logic [15:0]      cmd_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [15:0]      angle_word_reg;
    logic [15:0]      safety_word_reg;
    logic             stage_ready;
    logic             load;
    afsc_pkg::check_t check;

    assign load    = in_valid_reg && stage_ready;
    assign s_ready = !in_valid_reg || stage_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cmd_reg      <= afsc_pkg::CMD_WORD_RESET;
            cmd_word_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            cmd_word_reg <= cfg_wr_en;
            if (cfg_wr_en) begin
                cmd_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            angle_word_reg  <= s_angle_word;
            safety_word_reg <= s_safety_word;
        end
    end

    afsc_check u_check (
        .cmd_word    (cmd_reg),
        .angle_word  (angle_word_reg),
        .safety_word (safety_word_reg),
        .result      (check)
    );

    afsc_out_stage u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (load),
        .check           (check),
        .stage_ready     (stage_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_angle         (m_angle),
        .m_valid_res     (m_valid_res),
        .m_error_code    (m_error_code),
        .m_reset_request (m_reset_request),
        .m_last_safety   (m_last_safety)
    );

    // the command word only changes on a write
    a_cmd_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_wr_en |=> $stable(cmd_reg))
        else $error("command word changed without a write");

    // a write lands in the register in the cycle after cfg_wr_en
    a_cmd_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_word_reg |-> (cmd_reg == $past(cfg_wr_data)))
        else $error("command word write lost");

    // the input stage never drops a waiting frame
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !stage_ready) |=> (in_valid_reg && $stable(angle_word_reg)))
        else $error("stalled input frame lost");

endmodule
